>>> design/lsp_pkg.sv
// Shared types and constants of the line sensor position estimator.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lsp_pkg;

  localparam int RAW_W       = 12;
  localparam int LVL_W       = 11;
  localparam int POS_W       = 12;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int LEVEL_ONE   = 1024;
  localparam int FALLBACK_POS = 1536;

  typedef enum logic [1:0] {
    ACT_CAL_START = 2'd0,
    ACT_CAL_FRAME = 2'd1,
    ACT_MEASURE   = 2'd2,
    ACT_CAL_END   = 2'd3
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DZ_LOW    = 3'd0,
    REG_DZ_HIGH   = 3'd1,
    REG_LOST_THR  = 3'd2,
    REG_NEW_WT    = 3'd3,
    REG_SIDE_THR  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic accept;
    logic avg_go;
    logic nrm_go;
    logic lvl_wr;
    logic cen_go;
    logic cen_take;
    logic mul1;
    logic mul2;
    logic pos_ld;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic trigger;
    logic div_done;
    logic nrm_skip;
    logic nrm_fast;
    logic last;
    logic lost;
    logic den_zero;
    logic out_busy;
  } stat_t;

endpackage

>>> design/lsp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the datapath for the calibrated normalization and the centroid division.
`timescale 1ns / 1ps

module lsp_div #(
  parameter int W = 28
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo
);

  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [W:0]       trial;

  always_comb begin
    trial   = {rem_r, quo_r[W-1]} - {1'b0, dvs_r};
    rem_nxt = trial[W] ? {rem_r[W-2:0], quo_r[W-1]} : trial[W-1:0];
    quo_nxt = {quo_r[W-2:0], ~trial[W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= CNT_W'(W - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> design/lsp_dp.sv
// Datapath: calibration ranges, frame sums, normalization, centroid,
// smoothing and the result register. Depends on lsp_pkg and lsp_div.
`timescale 1ns / 1ps

module lsp_dp #(
  parameter int SENSOR_COUNT   = 6,
  parameter int AVG_FRAMES     = 5,
  parameter int ADC_FULL_SCALE = 4095,
  parameter int IN_DW          = 72,
  parameter int OUT_DW         = 80
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lsp_pkg::cmd_t                   cmd,
  output lsp_pkg::stat_t                  stat,
  input  logic [IN_DW-1:0]                in_tdata,
  input  logic [1:0]                      in_tuser,
  input  logic                            cfg_we,
  input  logic [lsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsp_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_DW-1:0]               out_tdata,
  output logic                            out_tuser
);
  import lsp_pkg::*;

  localparam int IDX_W  = $clog2(SENSOR_COUNT);
  localparam int WT_W   = IDX_W + 2;
  localparam int FR_W   = $clog2(AVG_FRAMES + 1);
  localparam int SUM_W  = $clog2(AVG_FRAMES * 4095 + 1);
  localparam int FS_W   = $clog2(ADC_FULL_SCALE + 1);
  localparam int CAL_W  = (FS_W > RAW_W) ? FS_W : RAW_W;
  localparam int NUM_W  = 12 + WT_W + IDX_W;
  localparam int DEN_W  = LVL_W + IDX_W + 1;
  localparam int DIV_W  = (NUM_W + 8 > CAL_W + 11) ? NUM_W + 8 : CAL_W + 11;
  localparam int CEN_W  = IDX_W + 9;
  localparam int ACC_W  = CEN_W + 12;
  localparam int S_W    = ACC_W - 8;

  // reciprocal constants for the divisions by AVG_FRAMES and by full scale
  localparam int     AVG_K   = SUM_W + 3;
  localparam int     AVG_M_W = AVG_K + 1;
  localparam int     AVG_M   = ((1 << AVG_K) + AVG_FRAMES - 1) / AVG_FRAMES;
  localparam int     AP_W    = SUM_W + AVG_M_W;
  localparam int     FS_K    = 2 * FS_W + 10;
  localparam int     FS_M_W  = FS_W + 12;
  localparam longint FS_M    = ((longint'(1) << FS_K) + longint'(ADC_FULL_SCALE) - 1) /
                               longint'(ADC_FULL_SCALE);
  localparam int     FP_W    = FS_W + FS_M_W;

  // configuration
  logic [LVL_W-1:0] dz_low_r, dz_high_r, side_thr_r;
  logic [12:0]      lost_thr_r;
  logic [8:0]       new_wt_r;

  // persistent state
  logic [CAL_W-1:0] cal_lo_r [SENSOR_COUNT];
  logic [CAL_W-1:0] cal_hi_r [SENSOR_COUNT];
  logic [SUM_W-1:0] sum_r    [SENSOR_COUNT];
  logic             calibrated_r;
  logic [FR_W-1:0]  frames_r;
  logic signed [POS_W-1:0] prev_r;

  // working registers
  logic [IDX_W-1:0]        idx_r;
  logic [RAW_W-1:0]        avg_r;
  logic [DIV_W-1:0]        fq_r;
  logic signed [NUM_W-1:0] num_r;
  logic [DEN_W-1:0]        den_r;
  logic                    nrm_skip_r, lost_r, neg_r;
  logic signed [CEN_W-1:0] cen_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [POS_W-1:0] pos_r;
  logic [LVL_W-1:0]        lvl_r [SENSOR_COUNT];

  // result register
  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic                    out_lost_r;
  logic [LVL_W-1:0]        out_lvl_r [SENSOR_COUNT];

  logic [RAW_W-1:0] raw [SENSOR_COUNT];
  act_t             action;
  logic             trigger;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q;

  logic [AP_W-1:0]  avg_prod;
  logic [FP_W-1:0]  fs_prod;
  logic [DIV_W-1:0] fs_q;
  logic [CAL_W-1:0] hi, lo;
  logic             nrm_skip;
  logic [DIV_W-1:0] nrm_a, nrm_b;

  logic [DIV_W-1:0]        v_raw;
  logic [LVL_W-1:0]        v_clamp, v;
  logic signed [WT_W-1:0]  wt;
  logic signed [NUM_W-1:0] prod_num;
  logic [NUM_W-1:0]        num_mag;
  logic                    lost, den_zero;

  logic [8:0]              w_eff, w_inv;
  logic signed [ACC_W-1:0] prod1, prod2, acc_adj;
  logic signed [S_W-1:0]   s;
  logic signed [POS_W-1:0] s_sat, fallback;
  logic signed [POS_W:0]   prev_x, side_x;

  always_comb begin
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      raw[i] = in_tdata[RAW_W*i +: RAW_W];
    end
    action  = act_t'(in_tuser);
    trigger = (frames_r == FR_W'(AVG_FRAMES - 1));
  end

  // average by reciprocal multiplication, exact over the whole sum range
  always_comb begin
    avg_prod = AP_W'(sum_r[idx_r]) * AP_W'(AVG_M);
  end

  // normalization operands for the current sensor
  always_comb begin
    hi      = cal_hi_r[idx_r];
    lo      = cal_lo_r[idx_r];
    nrm_a   = DIV_W'(hi - CAL_W'(avg_r)) << 10;
    nrm_b   = DIV_W'(hi - lo);
    fs_prod = FP_W'(CAL_W'(ADC_FULL_SCALE) - CAL_W'(avg_r)) * FP_W'(FS_M);
    fs_q    = DIV_W'(fs_prod >> (FS_K - 10));
    if (calibrated_r) begin
      nrm_skip = (hi <= lo) || (CAL_W'(avg_r) >= hi);
    end else begin
      nrm_skip = (CAL_W'(avg_r) >= CAL_W'(ADC_FULL_SCALE));
    end
  end

  // clamp and deadzone; low test before high
  always_comb begin
    v_raw   = nrm_skip_r ? '0 : (calibrated_r ? div_q : fq_r);
    v_clamp = (v_raw > DIV_W'(LEVEL_ONE)) ? LVL_W'(LEVEL_ONE) : v_raw[LVL_W-1:0];
    v       = v_clamp;
    if (v < dz_low_r) v = '0;
    if (v > dz_high_r) v = LVL_W'(LEVEL_ONE);
    wt       = $signed({1'b0, idx_r, 1'b0}) - $signed(WT_W'(SENSOR_COUNT - 1));
    prod_num = NUM_W'($signed({1'b0, v}) * wt);
  end

  always_comb begin
    num_mag  = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    lost     = 32'(den_r) < 32'(lost_thr_r);
    den_zero = (den_r == '0);
  end

  always_comb begin
    div_start = (cmd.nrm_go && !nrm_skip && calibrated_r) ||
                (cmd.cen_go && !lost && !den_zero);
    if (cmd.nrm_go) begin
      div_a = nrm_a;
      div_b = nrm_b;
    end else begin
      div_a = DIV_W'(num_mag) << 8;
      div_b = DIV_W'(den_r);
    end
  end

  lsp_div #(.W(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q)
  );

  // smoothing and position
  always_comb begin
    w_eff   = (new_wt_r > 9'd256) ? 9'd256 : new_wt_r;
    w_inv   = 9'd256 - w_eff;
    prod1   = ACC_W'($signed({1'b0, w_eff}) * cen_r);
    prod2   = ACC_W'($signed({1'b0, w_inv}) * prev_r);
    acc_adj = acc_r[ACC_W-1] ? acc_r + ACC_W'(255) : acc_r;
    s       = S_W'(acc_adj >>> 8);
    if (s > $signed(S_W'(2047))) begin
      s_sat = POS_W'(2047);
    end else if (s < -$signed(S_W'(2048))) begin
      s_sat = -POS_W'(2048);
    end else begin
      s_sat = POS_W'(s);
    end
    prev_x = {prev_r[POS_W-1], prev_r};
    side_x = $signed({2'b00, side_thr_r});
    if (prev_x < -side_x) begin
      fallback = -POS_W'(FALLBACK_POS);
    end else begin
      fallback = POS_W'(FALLBACK_POS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_low_r     <= LVL_W'(102);
      dz_high_r    <= LVL_W'(922);
      lost_thr_r   <= 13'd31;
      new_wt_r     <= 9'd179;
      side_thr_r   <= LVL_W'(51);
      calibrated_r <= 1'b0;
      frames_r     <= '0;
      prev_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        cal_lo_r[i] <= CAL_W'(ADC_FULL_SCALE);
        cal_hi_r[i] <= '0;
        sum_r[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DZ_LOW:   dz_low_r   <= cfg_wdata[LVL_W-1:0];
          REG_DZ_HIGH:  dz_high_r  <= cfg_wdata[LVL_W-1:0];
          REG_LOST_THR: lost_thr_r <= cfg_wdata;
          REG_NEW_WT:   new_wt_r   <= cfg_wdata[8:0];
          REG_SIDE_THR: side_thr_r <= cfg_wdata[LVL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        case (action)
          ACT_CAL_START: begin
            calibrated_r <= 1'b0;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              cal_lo_r[i] <= CAL_W'(ADC_FULL_SCALE);
              cal_hi_r[i] <= '0;
            end
          end
          ACT_CAL_FRAME: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              if (CAL_W'(raw[i]) < cal_lo_r[i]) cal_lo_r[i] <= CAL_W'(raw[i]);
              if (CAL_W'(raw[i]) > cal_hi_r[i]) cal_hi_r[i] <= CAL_W'(raw[i]);
            end
          end
          ACT_CAL_END: calibrated_r <= 1'b1;
          ACT_MEASURE: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              sum_r[i] <= sum_r[i] + SUM_W'(raw[i]);
            end
            frames_r <= trigger ? '0 : frames_r + 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.lvl_wr) sum_r[idx_r] <= '0;
      if (cmd.pos_ld && !lost_r) prev_r <= s_sat;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && trigger) begin
      idx_r <= '0;
      num_r <= '0;
      den_r <= '0;
    end
    if (cmd.avg_go) avg_r <= avg_prod[AVG_K +: RAW_W];
    if (cmd.nrm_go) begin
      nrm_skip_r <= nrm_skip;
      fq_r       <= fs_q;
    end
    if (cmd.lvl_wr) begin
      lvl_r[idx_r] <= v;
      num_r        <= num_r + prod_num;
      den_r        <= den_r + DEN_W'(v);
      idx_r        <= idx_r + 1'b1;
    end
    if (cmd.cen_go) begin
      lost_r <= lost;
      neg_r  <= num_r[NUM_W-1];
      cen_r  <= '0;
    end
    if (cmd.cen_take) begin
      cen_r <= neg_r ? -$signed(div_q[CEN_W-1:0]) : $signed(div_q[CEN_W-1:0]);
    end
    if (cmd.mul1) acc_r <= prod1;
    if (cmd.mul2) acc_r <= acc_r + prod2;
    if (cmd.pos_ld) pos_r <= lost_r ? fallback : s_sat;
    if (cmd.out_ld) begin
      out_pos_r  <= pos_r;
      out_lost_r <= lost_r;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        out_lvl_r[i] <= lvl_r[i];
      end
    end
  end

  always_comb begin
    out_tdata = '0;
    out_tdata[POS_W-1:0] = out_pos_r;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      out_tdata[POS_W + LVL_W*i +: LVL_W] = out_lvl_r[i];
    end
  end

  assign out_tuser  = out_lost_r;
  assign out_tvalid = out_valid_r;

  always_comb begin
    stat.trigger  = (action == ACT_MEASURE) && trigger;
    stat.div_done = div_done;
    stat.nrm_skip = nrm_skip;
    stat.nrm_fast = !calibrated_r;
    stat.last     = (idx_r == IDX_W'(SENSOR_COUNT - 1));
    stat.lost     = lost;
    stat.den_zero = den_zero;
    stat.out_busy = out_valid_r && !out_tready;
  end

endmodule

>>> design/lsp_ctrl.sv
// Controller: sequences per-sensor average, normalization and level steps,
// then centroid, smoothing and result load. Depends on lsp_pkg.
`timescale 1ns / 1ps

module lsp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  lsp_pkg::stat_t stat,
  output lsp_pkg::cmd_t  cmd
);
  import lsp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_AVG_GO   = 11'b000_0000_0010,
    S_NRM_GO   = 11'b000_0000_0100,
    S_NRM_WAIT = 11'b000_0000_1000,
    S_LVL      = 11'b000_0001_0000,
    S_CEN_GO   = 11'b000_0010_0000,
    S_CEN_WAIT = 11'b000_0100_0000,
    S_MUL1     = 11'b000_1000_0000,
    S_MUL2     = 11'b001_0000_0000,
    S_POS      = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.accept   = in_tvalid && in_tready;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && stat.trigger) state_nxt = S_AVG_GO;
      end
      S_AVG_GO: begin
        cmd.avg_go = 1'b1;
        state_nxt  = S_NRM_GO;
      end
      S_NRM_GO: begin
        cmd.nrm_go = 1'b1;
        state_nxt  = (stat.nrm_skip || stat.nrm_fast) ? S_LVL : S_NRM_WAIT;
      end
      S_NRM_WAIT: begin
        if (stat.div_done) state_nxt = S_LVL;
      end
      S_LVL: begin
        cmd.lvl_wr = 1'b1;
        state_nxt  = stat.last ? S_CEN_GO : S_AVG_GO;
      end
      S_CEN_GO: begin
        cmd.cen_go = 1'b1;
        if (stat.lost) begin
          state_nxt = S_POS;
        end else if (stat.den_zero) begin
          state_nxt = S_MUL1;
        end else begin
          state_nxt = S_CEN_WAIT;
        end
      end
      S_CEN_WAIT: begin
        if (stat.div_done) begin
          cmd.cen_take = 1'b1;
          state_nxt    = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_POS;
      end
      S_POS: begin
        cmd.pos_ld = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // hold until the result register frees up
        if (!stat.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == S_NRM_WAIT || state_r == S_CEN_WAIT))
    else $error("divider finished outside a wait state");
  a_last_to_cen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LVL && stat.last) |=> (state_r == S_CEN_GO))
    else $error("last level did not start centroid");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !stat.out_busy)
    else $error("result loaded over a pending transaction");
  a_pos_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pos_ld |=> (state_r == S_OUT))
    else $error("position load not followed by result stage");
`endif

endmodule

>>> design/line_sensor_position_estimator.sv
// Top level of the line sensor position estimator.
// Joins lsp_ctrl and lsp_dp; depends on lsp_pkg.
//
//  channel | direction | tdata                         | tuser
//  in_     | slave     | raw_0..raw_N-1, 12 bit each   | action (2 bit)
//  out_    | master    | position 12, level_0..N-1 11  | line_lost
//  cfg_    | write     | cfg_wdata 13 bit, cfg_index   | -
//
// Calibration frames and non-final measure frames are accepted without a stall.
// The final frame of an averaging run holds in_tready low while the controller
// works through every sensor, the centroid, smoothing and the result load, using the
// shared bit-serial divider; uncalibrated levels bypass the divider.
// Reset restores register defaults, calibration, sums and the previous position.
// A stalled result holds in its register while the next frames are accepted.
`timescale 1ns / 1ps

module line_sensor_position_estimator #(
  parameter int SENSOR_COUNT   = 6,
  parameter int AVG_FRAMES     = 5,
  parameter int ADC_FULL_SCALE = 4095
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // raw_0 .. raw_(SENSOR_COUNT-1), 12 bit each, from bit 0 up
  input  logic [((12*SENSOR_COUNT+7)/8)*8-1:0] in_tdata,
  // action
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // position (12, signed), level_0 .. level_(SENSOR_COUNT-1) (11 each), from bit 0 up
  output logic [((12+11*SENSOR_COUNT+7)/8)*8-1:0] out_tdata,
  // line_lost
  output logic                          out_tuser,
  input  logic                          cfg_we,
  input  logic [lsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsp_pkg::CFG_W-1:0]     cfg_wdata
);
  import lsp_pkg::*;

  localparam int IN_DW  = ((12 * SENSOR_COUNT + 7) / 8) * 8;
  localparam int OUT_DW = ((12 + 11 * SENSOR_COUNT + 7) / 8) * 8;

  cmd_t  cmd;
  stat_t stat;

  lsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lsp_dp #(
    .SENSOR_COUNT   (SENSOR_COUNT),
    .AVG_FRAMES     (AVG_FRAMES),
    .ADC_FULL_SCALE (ADC_FULL_SCALE),
    .IN_DW          (IN_DW),
    .OUT_DW         (OUT_DW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> dv/tb.sv
// Self-checking bench for line_sensor_position_estimator: directed frames, then
// random calibration and measure traffic under several register settings.
// Depends on lsp_pkg and the design top level.
`timescale 1ns / 1ps

module tb;
  import lsp_pkg::*;

  localparam int NS         = 6;
  localparam int NAVG       = 5;
  localparam int FULL       = 4095;
  localparam int IN_W       = ((12*NS+7)/8)*8;
  localparam int OUT_W      = ((12+11*NS+7)/8)*8;
  localparam int SETTLE     = 600;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic signed [11:0] pos;
    logic               lost;
    logic [NS-1:0][10:0] lvl;
  } reading_t;

  typedef struct packed {
    act_t                act;
    logic [NS-1:0][11:0] raw;
    bit                  typed;
    reading_t            want;
  } frame_row_t;

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_tvalid = 0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic [1:0]       in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  line_sensor_position_estimator u_dut (.*);

  always #5 clk = ~clk;

  // predictor copy of registers and state
  int unsigned dz_low = 102, dz_high = 922, lost_thr = 31, new_wt = 179, side_thr = 51;
  int unsigned cal_lo[NS], cal_hi[NS], frame_sum[NS];
  int unsigned frames_in_run = 0;
  int          last_pos = 0;
  bit          is_calibrated = 0;

  reading_t   readings_due[$];
  frame_row_t directed_rows[$];
  bit         row_typed = 0;
  reading_t   row_want;
  int         mismatches = 0;
  int         stall_cycles = 0;
  int         burst_left = 0;
  int         items_sent = 0;

  initial begin
    for (int i = 0; i < NS; i++) begin
      cal_lo[i] = FULL;
      cal_hi[i] = 0;
      frame_sum[i] = 0;
    end
  end

  function automatic int unsigned level_of(int i, int unsigned avg);
    int unsigned v;
    if (is_calibrated) begin
      if (cal_hi[i] <= cal_lo[i] || avg >= cal_hi[i]) v = 0;
      else v = ((cal_hi[i] - avg) * LEVEL_ONE) / (cal_hi[i] - cal_lo[i]);
    end else begin
      if (avg >= FULL) v = 0;
      else v = ((FULL - avg) * LEVEL_ONE) / FULL;
    end
    if (v > LEVEL_ONE) v = LEVEL_ONE;
    if (v < dz_low) v = 0;
    if (v > dz_high) v = LEVEL_ONE;
    return v;
  endfunction

  // advance the predicted state by one frame; returns 1 when a reading is due
  function automatic bit frame_step(act_t a, logic [IN_W-1:0] d, output reading_t r);
    int unsigned raw[NS];
    int unsigned lv;
    longint num, den, cen, w, s;
    r = '0;
    for (int i = 0; i < NS; i++) raw[i] = 32'(d[12*i +: 12]);
    case (a)
      ACT_CAL_START: begin
        for (int i = 0; i < NS; i++) begin
          cal_lo[i] = FULL;
          cal_hi[i] = 0;
        end
        is_calibrated = 0;
        return 0;
      end
      ACT_CAL_FRAME: begin
        for (int i = 0; i < NS; i++) begin
          if (raw[i] < cal_lo[i]) cal_lo[i] = raw[i];
          if (raw[i] > cal_hi[i]) cal_hi[i] = raw[i];
        end
        return 0;
      end
      ACT_CAL_END: begin
        is_calibrated = 1;
        return 0;
      end
      default: ;
    endcase
    for (int i = 0; i < NS; i++) frame_sum[i] += raw[i];
    frames_in_run++;
    if (frames_in_run < NAVG) return 0;
    num = 0;
    den = 0;
    for (int i = 0; i < NS; i++) begin
      lv = level_of(i, frame_sum[i] / NAVG);
      frame_sum[i] = 0;
      r.lvl[i] = lv[10:0];
      num += longint'(lv) * (2*i - (NS-1));
      den += lv;
    end
    frames_in_run = 0;
    if (den < lost_thr) begin
      r.lost = 1;
      if (last_pos > int'(side_thr)) r.pos = 12'(FALLBACK_POS);
      else if (last_pos < -int'(side_thr)) r.pos = -12'(FALLBACK_POS);
      else r.pos = 12'(FALLBACK_POS);
    end else begin
      w = (new_wt > 256) ? 256 : new_wt;
      cen = (den != 0) ? (num * 256) / den : 0;
      s = (w * cen + (256 - w) * last_pos) / 256;
      if (s > 2047) s = 2047;
      if (s < -2048) s = -2048;
      r.pos = s[11:0];
      last_pos = int'(s);
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    reading_t r;
    if (rst_n && in_tvalid && in_tready) begin
      if (frame_step(act_t'(in_tuser), in_tdata, r))
        readings_due.push_back(row_typed ? row_want : r);
    end
  end

  function automatic void flag(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    reading_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (readings_due.size() == 0) begin
        flag("unexpected result, position", 0, $signed(out_tdata[11:0]));
      end else begin
        w = readings_due.pop_front();
        if (out_tdata[11:0] !== w.pos) flag("position", w.pos, $signed(out_tdata[11:0]));
        if (out_tuser !== w.lost) flag("line_lost", w.lost, out_tuser);
        for (int i = 0; i < NS; i++)
          if (out_tdata[12+11*i +: 11] !== w.lvl[i])
            flag($sformatf("level_%0d", i), w.lvl[i], out_tdata[12+11*i +: 11]);
      end
    end
  end

  // watchdog on cycles without any transaction or register write
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: switch between always ready, random and long stalls
  always @(negedge clk) begin
    int sel;
    sel = int'(($time / 2000) % 3);
    if (!rst_n) out_tready <= 0;
    else if (sel == 0) out_tready <= 1;
    else if (sel == 1) out_tready <= 1'($urandom_range(0, 1));
    else out_tready <= ($urandom_range(0, 15) == 0);
  end

  task automatic send_frame(act_t a, logic [NS-1:0][11:0] raw, bit typed, reading_t want);
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    row_typed = typed;
    row_want = want;
    in_tvalid <= 1;
    in_tuser <= a;
    in_tdata <= IN_W'(raw);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    case (idx)
      REG_DZ_LOW:   dz_low = val & 11'h7FF;
      REG_DZ_HIGH:  dz_high = val & 11'h7FF;
      REG_LOST_THR: lost_thr = val & 13'h1FFF;
      REG_NEW_WT:   new_wt = val & 9'h1FF;
      REG_SIDE_THR: side_thr = val & 11'h7FF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 0;
    burst_left = 0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [NS-1:0][11:0] same_raw(int unsigned v);
    logic [NS-1:0][11:0] r;
    for (int i = 0; i < NS; i++) r[i] = v[11:0];
    return r;
  endfunction

  function automatic logic [NS-1:0][11:0] random_raw();
    logic [NS-1:0][11:0] r;
    int c;
    int mode;
    mode = $urandom_range(0, 9);
    c = $urandom_range(0, NS-1);
    for (int i = 0; i < NS; i++) begin
      case (mode)
        0, 1:    r[i] = 12'($urandom_range(0, 4095));
        2:       r[i] = 12'hFFF;
        3:       r[i] = 12'h000;
        4:       r[i] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        default: r[i] = (i == c || i == c + 1 && mode > 6) ?
                        12'($urandom_range(0, 900)) : 12'($urandom_range(2800, 4095));
      endcase
    end
    return r;
  endfunction

  task automatic set_phase(int p);
    int unsigned v[5];
    case (p)
      0: v = '{102, 922, 31, 179, 51};
      1: v = '{0, 1024, 0, 256, 0};
      2: v = '{1024, 0, 6144, 0, 1536};
      3: v = '{0, 0, 1, 511, 2047};
      4: v = '{2047, 2047, 8191, 300, 1};
      5: v = '{$urandom_range(0, 300), $urandom_range(700, 1024), $urandom_range(0, 400),
               $urandom_range(0, 256), $urandom_range(0, 1536)};
      default: v = '{$urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 8191),
                     $urandom_range(0, 511), $urandom_range(0, 2047)};
    endcase
    for (int i = 0; i < 5; i++) write_reg(reg_idx_t'(i), v[i]);
  endtask

  initial begin
    reading_t zero_line, all_dark;
    frame_row_t row;
    int pick;
    zero_line = '{pos: 0, lost: 0, lvl: {NS{11'd1024}}};
    all_dark = '{pos: FALLBACK_POS, lost: 1, lvl: '0};

    // all-black frames give a centered line; all-white frames lose it
    for (int k = 0; k < NAVG; k++)
      directed_rows.push_back('{ACT_MEASURE, same_raw(0), k == NAVG-1, zero_line});
    for (int k = 0; k < NAVG; k++)
      directed_rows.push_back('{ACT_MEASURE, same_raw(4095), k == NAVG-1, all_dark});
    // calibration with two flat sensors (degenerate ranges), partial and full-range sensors
    directed_rows.push_back('{ACT_CAL_START, same_raw(0), 0, '0});
    directed_rows.push_back('{ACT_CAL_FRAME, {12'd4095, 12'd1234, 12'd2000, 12'd100,
                                              12'd4095, 12'd0}, 0, '0});
    directed_rows.push_back('{ACT_CAL_FRAME, {12'd4095, 12'd1, 12'd2000, 12'd3000,
                                              12'd0, 12'd4095}, 0, '0});
    directed_rows.push_back('{ACT_CAL_END, same_raw(4095), 0, '0});
    for (int k = 0; k < NAVG; k++)
      directed_rows.push_back('{ACT_MEASURE, {12'd800, 12'd3000, 12'd2000, 12'd1500,
                                              12'd4095, 12'(k*900)}, 0, '0});
    // empty calibration leaves every range degenerate
    directed_rows.push_back('{ACT_CAL_START, same_raw(0), 0, '0});
    directed_rows.push_back('{ACT_CAL_END, same_raw(0), 0, '0});
    for (int k = 0; k < NAVG; k++)
      directed_rows.push_back('{ACT_MEASURE, random_raw(), 0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    set_phase(0);

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      send_frame(row.act, row.raw, row.typed, row.want);
    end
    drain();

    for (int p = 1; p <= 7; p++) begin
      set_phase(p);
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_frame(ACT_CAL_START, random_raw(), 0, '0);
          repeat ($urandom_range(1, 6)) send_frame(ACT_CAL_FRAME, random_raw(), 0, '0);
          send_frame(ACT_CAL_END, random_raw(), 0, '0);
        end else if (pick < 14) begin
          send_frame(act_t'($urandom_range(0, 3)), random_raw(), 0, '0);
        end else begin
          repeat (NAVG) send_frame(ACT_MEASURE, random_raw(), 0, '0);
        end
      end
      drain();
    end

    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/lsp_pkg.sv
design/lsp_div.sv
design/lsp_dp.sv
design/lsp_ctrl.sv
design/line_sensor_position_estimator.sv
dv/tb.sv
